FILE: rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared definitions for the bounded deque
// Sizes, request codes, cell control and output word formatting.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;
  localparam int KIND_W    = 3;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_REAR  = 3'd5
  } kind_t;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
    logic load;
  } cell_ctl_t;

  function automatic logic [DATA_W-1:0] word_out(input logic [WORD_BITS-1:0] w);
    logic signed [WORD_BITS-1:0] s;
    s = w;
    return DATA_W'(s);
  endfunction

endpackage

FILE: rtl/core/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell: one storage cell of the deque chain
// Holds one word and takes it from its front neighbor, its rear neighbor or
// the pushed word, as its control tells it.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                           clk,
  input  bdq_pkg::cell_ctl_t             ctl,
  input  logic [bdq_pkg::WORD_BITS-1:0]  from_front,
  input  logic [bdq_pkg::WORD_BITS-1:0]  from_rear,
  input  logic [bdq_pkg::WORD_BITS-1:0]  load_word,
  output logic [bdq_pkg::WORD_BITS-1:0]  word
);

  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      word <= from_front;
    end else if (ctl.shift_out) begin
      word <= from_rear;
    end else if (ctl.load) begin
      word <= load_word;
    end
  end

endmodule

FILE: rtl/core/bounded_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque: bounded double-ended queue of signed words
// A chain of cells keeps the front entry in the first cell; front pushes and
// pops move the whole chain by one place, rear pushes load the cell after
// the last entry.
//
// Channel   Handshake                     Payload
// input     in_valid / in_stall           kind, value
// output    out_valid / out_stall         ok, data, occupancy, is_empty, is_full
// config    cfg_write                     cfg_data (capacity)
//
// Every request yields its result in the output register on the next cycle;
// one transaction can be accepted on every clock while the input is not stalled.
// The chain shifts in the same cycle a request is accepted, so there is no
// dependency stall between requests.
// Reset clears the entry count and the output valid flag and sets capacity
// to 16.
// The input stalls only while a result waits in the output register and the
// output is stalled.
// ----------------------------------------------------------------------------
module bounded_deque (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bdq_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdq_pkg::KIND_W-1:0]    kind,
  input  logic signed [bdq_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic signed [bdq_pkg::DATA_W-1:0] data,
  output logic [bdq_pkg::OCC_W-1:0]     occupancy,
  output logic                          is_empty,
  output logic                          is_full
);

  logic [bdq_pkg::CAP_W-1:0]     capacity;
  logic [bdq_pkg::CNT_W-1:0]     count;
  logic [bdq_pkg::CNT_W-1:0]     count_next;
  logic [bdq_pkg::CMP_W-1:0]     cap_ext;
  logic [bdq_pkg::CMP_W-1:0]     cap_sat;
  logic [bdq_pkg::CMP_W-1:0]     count_ext;
  logic [bdq_pkg::CMP_W-1:0]     count_next_ext;
  logic [bdq_pkg::IDX_W-1:0]     rear_idx;
  logic [bdq_pkg::WORD_BITS-1:0] push_word;
  logic [bdq_pkg::WORD_BITS-1:0] words [bdq_pkg::DEPTH];
  bdq_pkg::cell_ctl_t            ctls  [bdq_pkg::DEPTH];
  logic                          accept;
  logic                          has_room;
  logic                          has_entry;
  logic                          do_push_front;
  logic                          do_push_rear;
  logic                          do_pop_front;
  logic                          ok_next;
  logic [bdq_pkg::DATA_W-1:0]    data_next;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign push_word = bdq_pkg::WORD_BITS'(value);

  assign cap_ext   = bdq_pkg::CMP_W'(capacity);
  assign cap_sat   = (cap_ext > bdq_pkg::CMP_W'(bdq_pkg::DEPTH)) ?
                     bdq_pkg::CMP_W'(bdq_pkg::DEPTH) : cap_ext;
  assign count_ext = bdq_pkg::CMP_W'(count);
  assign has_room  = count_ext < cap_sat;
  assign has_entry = count != '0;
  assign rear_idx  = bdq_pkg::IDX_W'(count - bdq_pkg::CNT_W'(1));

  always_comb begin
    do_push_front = 1'b0;
    do_push_rear  = 1'b0;
    do_pop_front  = 1'b0;
    ok_next       = 1'b0;
    data_next     = '0;
    count_next    = count;
    case (kind)
      bdq_pkg::KIND_PUSH_FRONT: begin
        if (has_room) begin
          do_push_front = 1'b1;
          ok_next       = 1'b1;
          count_next    = count + bdq_pkg::CNT_W'(1);
        end
      end
      bdq_pkg::KIND_PUSH_REAR: begin
        if (has_room) begin
          do_push_rear = 1'b1;
          ok_next      = 1'b1;
          count_next   = count + bdq_pkg::CNT_W'(1);
        end
      end
      bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_PEEK_FRONT: begin
        if (has_entry) begin
          ok_next   = 1'b1;
          data_next = bdq_pkg::word_out(words[0]);
          if (kind == bdq_pkg::KIND_POP_FRONT) begin
            do_pop_front = 1'b1;
            count_next   = count - bdq_pkg::CNT_W'(1);
          end
        end else begin
          data_next = '1;
        end
      end
      bdq_pkg::KIND_POP_REAR, bdq_pkg::KIND_PEEK_REAR: begin
        if (has_entry) begin
          ok_next   = 1'b1;
          data_next = bdq_pkg::word_out(words[rear_idx]);
          if (kind == bdq_pkg::KIND_POP_REAR) begin
            count_next = count - bdq_pkg::CNT_W'(1);
          end
        end else begin
          data_next = '1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign count_next_ext = bdq_pkg::CMP_W'(count_next);

  for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
    logic [bdq_pkg::WORD_BITS-1:0] from_front;
    logic [bdq_pkg::WORD_BITS-1:0] from_rear;

    if (i == 0) begin : g_first
      assign from_front = push_word;
    end else begin : g_mid
      assign from_front = words[i-1];
    end

    if (i == bdq_pkg::DEPTH - 1) begin : g_last
      assign from_rear = words[i];
    end else begin : g_inner
      assign from_rear = words[i+1];
    end

    assign ctls[i].shift_in  = accept && do_push_front;
    assign ctls[i].shift_out = accept && do_pop_front;
    assign ctls[i].load      = accept && do_push_rear &&
                               (count == bdq_pkg::CNT_W'(i));

    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctls[i]),
      .from_front (from_front),
      .from_rear  (from_rear),
      .load_word  (push_word),
      .word       (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bdq_pkg::CAP_W'(16);
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok        <= ok_next;
      data      <= data_next;
      occupancy <= bdq_pkg::OCC_W'(count_next);
      is_empty  <= (count_next == '0);
      is_full   <= (count_next_ext >= cap_sat);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count_ext <= bdq_pkg::CMP_W'(bdq_pkg::DEPTH))
    else $error("Entry count exceeds the storage depth.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (occupancy == '0)))
    else $error("Empty flag disagrees with the reported occupancy.");

  assert property (@(posedge clk) disable iff (rst)
    (accept && (do_push_front || do_push_rear)) |=>
      (count == $past(count) + bdq_pkg::CNT_W'(1)) && ok)
    else $error("Successful push did not raise the entry count by one.");

  assert property (@(posedge clk) disable iff (rst)
    (accept && !ok_next) |=> (count == $past(count)))
    else $error("Failed transaction changed the entry count.");

endmodule

FILE: tb/sv/bounded_deque_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_test: self-checking testbench for the bounded deque
// A short scripted sequence covers the empty-queue misses, the spare request
// codes, the word extremes and the capacity corner settings. Random traffic
// then runs in phases, each with its own capacity. Push and pop weights drift
// so that the queue reaches both full and empty. Results are compared with a
// cycle-free model of the deque, some scripted rows with fixed results. The
// sender pauses in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module bounded_deque_test;

  localparam logic [bdq_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [bdq_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 50;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic                       ok;
    logic [bdq_pkg::DATA_W-1:0] data;
    logic [bdq_pkg::OCC_W-1:0]  occupancy;
    logic                       is_empty;
    logic                       is_full;
  } deque_result_t;

  typedef struct {
    bit                         is_cfg;
    logic [bdq_pkg::CAP_W-1:0]  cap;
    logic [bdq_pkg::KIND_W-1:0] op;
    logic [bdq_pkg::DATA_W-1:0] word;
    bit                         typed;
    deque_result_t              want;
  } script_row_t;

  localparam deque_result_t EMPTY_MISS = '{ok: 1'b0, data: 32'hFFFF_FFFF, occupancy: '0,
                                           is_empty: 1'b1, is_full: 1'b0};
  localparam deque_result_t SPARE_IDLE = '{ok: 1'b0, data: '0, occupancy: '0,
                                           is_empty: 1'b1, is_full: 1'b0};

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [bdq_pkg::CAP_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [bdq_pkg::KIND_W-1:0]        kind = '0;
  logic signed [bdq_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              ok;
  logic signed [bdq_pkg::DATA_W-1:0] data;
  logic [bdq_pkg::OCC_W-1:0]         occupancy;
  logic                              is_empty;
  logic                              is_full;

  bounded_deque u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .data      (data),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [bdq_pkg::DATA_W-1:0] model_slots [bdq_pkg::DEPTH];
  logic [bdq_pkg::IDX_W-1:0]  model_front;
  logic [bdq_pkg::IDX_W-1:0]  model_rear;
  int                         model_count;
  logic [bdq_pkg::CAP_W-1:0]  model_capacity;

  deque_result_t pending_results [$];
  script_row_t   script [$];

  int mismatch_count = 0;
  int results_checked = 0;
  int refused_count = 0;
  int full_seen = 0;
  int kind_seen [8];
  int cycle_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int cap_settings = 0;

  function automatic deque_result_t apply_request(input logic [bdq_pkg::KIND_W-1:0] op,
                                                  input logic [bdq_pkg::DATA_W-1:0] word);
    deque_result_t res;
    int            limit;
    limit = (model_capacity > bdq_pkg::DEPTH) ? bdq_pkg::DEPTH : int'(model_capacity);
    res = '0;
    case (op)
      bdq_pkg::KIND_PUSH_FRONT: begin
        if (model_count < limit) begin
          model_front = model_front - 1'b1;
          model_slots[model_front] = word;
          model_count++;
          res.ok = 1'b1;
        end
      end
      bdq_pkg::KIND_PUSH_REAR: begin
        if (model_count < limit) begin
          model_slots[model_rear] = word;
          model_rear = model_rear + 1'b1;
          model_count++;
          res.ok = 1'b1;
        end
      end
      bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_REAR, bdq_pkg::KIND_PEEK_FRONT,
      bdq_pkg::KIND_PEEK_REAR: begin
        if (model_count == 0) begin
          res.data = '1;
        end else begin
          res.ok = 1'b1;
          if (op == bdq_pkg::KIND_POP_FRONT) begin
            res.data = model_slots[model_front];
            model_front = model_front + 1'b1;
            model_count--;
          end else if (op == bdq_pkg::KIND_POP_REAR) begin
            model_rear = model_rear - 1'b1;
            res.data = model_slots[model_rear];
            model_count--;
          end else if (op == bdq_pkg::KIND_PEEK_FRONT) begin
            res.data = model_slots[model_front];
          end else begin
            res.data = model_slots[bdq_pkg::IDX_W'(model_rear - 1'b1)];
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = bdq_pkg::OCC_W'(model_count);
    res.is_empty = (model_count == 0);
    res.is_full = (model_count >= limit);
    return res;
  endfunction

  function automatic script_row_t request_row(input logic [bdq_pkg::KIND_W-1:0] op,
                                              input logic [bdq_pkg::DATA_W-1:0] word);
    script_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, op: op, word: word, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic script_row_t checked_row(input logic [bdq_pkg::KIND_W-1:0] op,
                                              input deque_result_t want);
    script_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, op: op, word: $urandom, typed: 1'b1, want: want};
    return row;
  endfunction

  function automatic script_row_t capacity_row(input logic [bdq_pkg::CAP_W-1:0] cap);
    script_row_t row;
    row = '{is_cfg: 1'b1, cap: cap, op: '0, word: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic logic [bdq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bdq_pkg::KIND_W-1:0] pick_kind(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? bdq_pkg::KIND_PUSH_REAR : bdq_pkg::KIND_PUSH_FRONT;
    case ($urandom_range(0, 3))
      0: return bdq_pkg::KIND_POP_FRONT;
      1: return bdq_pkg::KIND_POP_REAR;
      2: return bdq_pkg::KIND_PEEK_FRONT;
      default: return bdq_pkg::KIND_PEEK_REAR;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [bdq_pkg::DATA_W-1:0] got,
                                 input logic [bdq_pkg::DATA_W-1:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [bdq_pkg::KIND_W-1:0] op,
                              input logic [bdq_pkg::DATA_W-1:0] word,
                              input bit typed, input deque_result_t want);
    deque_result_t predicted;
    in_valid <= 1'b1;
    kind <= op;
    value <= word;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = apply_request(op, word);
    pending_results.push_back(typed ? want : predicted);
    kind_seen[op]++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic set_capacity(input logic [bdq_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
    model_capacity = cap;
    cap_settings++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      got = '{ok: ok, data: data, occupancy: occupancy, is_empty: is_empty, is_full: is_full};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction data", got.data, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (!want.ok) refused_count++;
        if (want.is_full) full_seen++;
        if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
        if (got.data !== want.data) report_mismatch("data", got.data, want.data);
        if (got.occupancy !== want.occupancy)
          report_mismatch("occupancy", got.occupancy, want.occupancy);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.is_full !== want.is_full) report_mismatch("is_full", got.is_full, want.is_full);
      end
    end
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 40);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    logic [bdq_pkg::CAP_W-1:0] phase_caps [8];
    int                        push_pct;
    model_front = '0;
    model_rear = '0;
    model_count = 0;
    model_capacity = 5'd16;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd17, 5'd3, 5'd16};

    script.push_back(checked_row(bdq_pkg::KIND_POP_FRONT, EMPTY_MISS));
    script.push_back(checked_row(bdq_pkg::KIND_POP_REAR, EMPTY_MISS));
    script.push_back(checked_row(bdq_pkg::KIND_PEEK_FRONT, EMPTY_MISS));
    script.push_back(checked_row(bdq_pkg::KIND_PEEK_REAR, EMPTY_MISS));
    script.push_back(checked_row(KIND_SPARE_LO, SPARE_IDLE));
    script.push_back(checked_row(KIND_SPARE_HI, SPARE_IDLE));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_REAR, 32'h8000_0000));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_REAR, 32'h0000_0000));
    script.push_back(request_row(bdq_pkg::KIND_PEEK_FRONT, 32'h1234_5678));
    script.push_back(request_row(bdq_pkg::KIND_PEEK_REAR, 32'h0));
    script.push_back(request_row(KIND_SPARE_HI, 32'hFFFF_FFFF));
    script.push_back(capacity_row(5'd2));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_REAR, 32'h5555_AAAA));
    script.push_back(request_row(bdq_pkg::KIND_POP_FRONT, 32'h0));
    script.push_back(request_row(bdq_pkg::KIND_POP_REAR, 32'h0));
    script.push_back(capacity_row(5'd0));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_FRONT, 32'hAAAA_5555));
    script.push_back(request_row(bdq_pkg::KIND_POP_FRONT, 32'h0));
    script.push_back(capacity_row(5'd31));
    script.push_back(request_row(bdq_pkg::KIND_PUSH_REAR, 32'h0000_0001));
    script.push_back(request_row(bdq_pkg::KIND_POP_REAR, 32'h0));
    script.push_back(request_row(bdq_pkg::KIND_POP_FRONT, 32'h0));
    script.push_back(checked_row(bdq_pkg::KIND_POP_REAR, EMPTY_MISS));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        set_capacity(script[i].cap);
      end else begin
        send_request(script[i].op, script[i].word, script[i].typed, script[i].want);
        pace_sender();
      end
    end

    push_pct = 50;
    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        send_request(pick_kind(push_pct), pick_word(), 1'b0, '0);
        pace_sender();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d pushes, %0d pops, %0d peeks and %0d spare requests",
             kind_seen[0] + kind_seen[1], kind_seen[2] + kind_seen[3],
             kind_seen[4] + kind_seen[5], kind_seen[6] + kind_seen[7]);
    $display("over %0d capacity settings; checked %0d results: %0d refused, %0d full, %0d mismatches.",
             cap_settings, results_checked, refused_count, full_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: bounded_deque.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque.sv
tb/sv/bounded_deque_test.sv
